@@ hw/rtl/mgsa_pkg.sv @@
// Package for the max-gap seat allocator: status codes, request kinds,
// register map and default sizes. No dependencies.
package mgsa_pkg;

  localparam int DEF_SEATS      = 256;
  localparam int DEF_REQUESTERS = 256;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_DEPART = 1'b1;

  // Register index (word address) on the config port.
  localparam logic REG_NUM_SEATS = 1'b0;

  localparam logic [8:0] NUM_SEATS_RST = 9'd256;

endpackage

@@ hw/rtl/max_gap_seat_allocator_unit.sv @@
// Max-gap seat allocator, top level: sequencer, shared gap unit, seat and
//   requester memories, APB-style config port.
// Depends on mgsa_pkg.
//
// Usage: raise start with kind and requester_id while busy is low; the
// request is taken at that edge and busy rises. One result comes back on
// seat/status with done high for exactly one cycle; the receiver cannot
// stall it. busy falls as done rises, and the next request may be issued.
// An arrival scans the occupancy memory one seat per clock through a
// single subtract/compare unit over n, the active seat count, then ends
// in S_FINISH; the scan loop over the one-read-port occupancy memory sets
// how long an arrival takes. A departure is one map lookup and one update,
// in S_LOOKUP then S_DEP. Only one request is in flight at a time: the
// next is taken only after the result of the last one.
// The user writes num_seats over the config port (byte address 0) only
// while idle; the block does not enforce this. Config writes are taken at
// all times. Reset: synchronous, active high. After reset a clearing pass
// writes both memories over max(SEATS, REQUESTERS) addresses (256 by
// default); busy stays high during it.
module max_gap_seat_allocator_unit
  import mgsa_pkg::*;
#(
  parameter int SEATS      = DEF_SEATS,
  parameter int REQUESTERS = DEF_REQUESTERS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [7:0]  requester_id,
  output logic        done,
  output logic [7:0]  seat,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW        = $clog2(SEATS);
  localparam int CW        = $clog2(SEATS + 1);
  localparam int RW        = $clog2(REQUESTERS);
  localparam int CLR_DEPTH = (SEATS > REQUESTERS) ? SEATS : REQUESTERS;
  localparam int KW        = $clog2(CLR_DEPTH);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_LOOKUP = 3'd4;
  localparam logic [2:0] S_DEP    = 3'd5;

  logic [2:0]    state;
  logic [8:0]    num_seats;
  logic [KW-1:0] clr;
  logic [CW-1:0] cnt;
  logic [CW-1:0] rd_pos;
  logic          rd_vld;
  logic          any_taken;
  logic [CW-1:0] prev;
  logic [CW-1:0] best;
  logic [CW-1:0] best_dist;
  logic [RW-1:0] id_q;

  logic          taken_mem [SEATS];
  logic          taken_q;
  logic [SW:0]   map_mem [REQUESTERS];
  logic [SW:0]   map_q;

  logic          accept;
  logic          cfg_wr;
  logic [CW-1:0] n_act;
  logic [RW-1:0] id_mod;
  logic [19:0]   id_r;
  logic [CW-1:0] sub_a;
  logic [CW-1:0] diff;
  logic [CW-1:0] cand;
  logic          gt;
  logic [CW-1:0] pick;
  logic [CW-1:0] fin_dist;
  logic          row_full;

  logic          taken_we;
  logic [SW-1:0] taken_waddr;
  logic          taken_wdata;
  logic          map_we;
  logic [RW-1:0] map_waddr;
  logic [SW:0]   map_wdata;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_NUM_SEATS);
  assign prdata = (paddr[2] == REG_NUM_SEATS) ? 32'(num_seats) : '0;

  always_comb begin
    if (num_seats == '0) begin
      n_act = CW'(1);
    end else if (int'(num_seats) > SEATS) begin
      n_act = CW'(SEATS);
    end else begin
      n_act = CW'(num_seats);
    end
  end

  // id mod REQUESTERS by restoring reduction
  always_comb begin
    id_r = 20'(requester_id);
    for (int k = 7; k >= 0; k--) begin
      if (id_r >= (20'(REQUESTERS) << k)) begin
        id_r = id_r - (20'(REQUESTERS) << k);
      end
    end
    id_mod = id_r[RW-1:0];
  end

  // shared gap unit
  assign sub_a = (state == S_FINISH) ? (n_act - CW'(1)) : rd_pos;
  assign diff  = sub_a - prev;
  assign cand  = (state == S_FINISH) ? diff : (diff >> 1);
  assign gt    = cand > best_dist;

  always_comb begin
    if (!any_taken) begin
      pick     = '0;
      fin_dist = CW'(1);
    end else if (gt) begin
      pick     = n_act - CW'(1);
      fin_dist = cand;
    end else begin
      pick     = best;
      fin_dist = best_dist;
    end
    row_full = (fin_dist == '0);
  end

  always_comb begin
    taken_we    = 1'b0;
    taken_waddr = pick[SW-1:0];
    taken_wdata = 1'b1;
    map_we      = 1'b0;
    map_waddr   = id_q;
    map_wdata   = {1'b1, pick[SW-1:0]};
    case (state)
      S_CLEAR: begin
        taken_we    = (int'(clr) < SEATS);
        taken_waddr = clr[SW-1:0];
        taken_wdata = 1'b0;
        map_we      = (int'(clr) < REQUESTERS);
        map_waddr   = clr[RW-1:0];
        map_wdata   = '0;
      end
      S_FINISH: begin
        taken_we = !row_full;
        map_we   = !row_full;
      end
      S_DEP: begin
        taken_we    = map_q[SW];
        taken_waddr = map_q[SW-1:0];
        taken_wdata = 1'b0;
        map_we      = map_q[SW];
        map_wdata   = '0;
      end
      default: begin
        taken_we = 1'b0;
        map_we   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (taken_we) begin
      taken_mem[taken_waddr] <= taken_wdata;
    end
    taken_q <= taken_mem[cnt[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_q <= map_mem[id_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_seats <= NUM_SEATS_RST;
    end else if (cfg_wr) begin
      num_seats <= pwdata[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      any_taken <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + KW'(1);
          if (int'(clr) == CLR_DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            id_q      <= id_mod;
            cnt       <= '0;
            rd_vld    <= 1'b0;
            any_taken <= 1'b0;
            prev      <= '0;
            best      <= '0;
            best_dist <= '0;
            state     <= (kind == KIND_DEPART) ? S_LOOKUP : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_vld && taken_q) begin
            if (!any_taken) begin
              any_taken <= 1'b1;
              if (rd_pos != '0) begin
                best_dist <= rd_pos;
                best      <= '0;
              end
            end else if (gt) begin
              best_dist <= cand;
              best      <= prev + cand;
            end
            prev <= rd_pos;
          end
          if (cnt < n_act) begin
            rd_pos <= cnt;
            rd_vld <= 1'b1;
            cnt    <= cnt + CW'(1);
          end else begin
            rd_vld <= 1'b0;
            state  <= S_FINISH;
          end
        end
        S_FINISH: begin
          done   <= 1'b1;
          seat   <= row_full ? 8'd0 : 8'(pick);
          status <= row_full ? ST_FULL : ST_OK;
          state  <= S_IDLE;
        end
        S_LOOKUP: begin
          state <= S_DEP;
        end
        S_DEP: begin
          done   <= 1'b1;
          seat   <= map_q[SW] ? 8'(map_q[SW-1:0]) : 8'd0;
          status <= map_q[SW] ? ST_OK : ST_UNKNOWN;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result without a request in flight");

  a_err_seat_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (seat == 8'd0))
    else $error("error result with nonzero seat");

  a_arrival_no_unknown: assert property (@(posedge clk) disable iff (rst)
    (done && $past(state) == S_FINISH) |-> (status != ST_UNKNOWN))
    else $error("arrival reported unknown requester");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not raise busy");

endmodule
